[hdl/hhf_pkg.sv]
// Shared types, constants and lookup functions of the hop-by-hop header filter.
// Used by every module of the block; depends on nothing else.
package hhf_pkg;

    localparam int LEN_W         = 16;
    localparam int NUM_NAMES     = 11;
    localparam int NAME_IDX_W    = 4;
    localparam int NAME_POS_W    = 5;
    localparam int TAIL_IDX_W    = 6;
    localparam int TAIL_HEAD_LEN = 16;
    localparam int TAIL_REST_LEN = 23;
    localparam int TAIL_BASE_LEN = TAIL_HEAD_LEN + TAIL_REST_LEN;
    localparam int BCD_W         = 20;
    localparam int CONV_STEPS    = 16;

    localparam logic [LEN_W-1:0] LEN_MAX    = '1;
    localparam logic [15:0]      HEADROOM   = 16'd64;
    localparam logic [15:0]      PORT_RESET = 16'd5173;
    localparam logic [15:0]      BUF_RESET  = 16'd16384;
    localparam logic [7:0]       CHAR_CR    = 8'h0d;
    localparam logic [7:0]       CHAR_LF    = 8'h0a;
    localparam logic [7:0]       CHAR_ZERO  = 8'h30;

    localparam logic [8*TAIL_HEAD_LEN-1:0] TAIL_HEAD = {
        "Host: ", 8'h31, 8'h32, 8'h37, 8'h2e, 8'h30, 8'h2e, 8'h30, 8'h2e, 8'h31, ":"
    };
    localparam logic [8*TAIL_REST_LEN-1:0] TAIL_REST = {
        CHAR_CR, CHAR_LF, "Connection: close", CHAR_CR, CHAR_LF, CHAR_CR, CHAR_LF
    };

    typedef enum logic [2:0] {
        VERDICT_FORWARD = 3'd0,
        VERDICT_HOP     = 3'd1,
        VERDICT_NO_ROOM = 3'd2,
        VERDICT_REQUEST = 3'd3,
        VERDICT_SMUGGLE = 3'd4,
        VERDICT_BLANK   = 3'd5
    } verdict_t;

    typedef enum logic {
        KIND_VERDICT = 1'b0,
        KIND_TAIL    = 1'b1
    } kind_t;

    typedef enum logic {
        CFG_PORT_NUMBER = 1'b0,
        CFG_BUFFER_SIZE = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        kind_t            kind;
        verdict_t         verdict;
        logic [LEN_W-1:0] line_length;
        logic [7:0]       tail_byte;
        logic [LEN_W-1:0] total_length;
        logic             last;
    } result_t;

    typedef struct packed {
        logic             start;
        logic [LEN_W-1:0] out_count;
    } tail_req_t;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
    endfunction

    function automatic logic [NAME_POS_W-1:0] name_len(input logic [NAME_IDX_W-1:0] k);
        logic [NAME_POS_W-1:0] len;
        unique case (k)
            4'd0:    len = 5'd5;
            4'd1:    len = 5'd11;
            4'd2:    len = 5'd18;
            4'd3:    len = 5'd3;
            4'd4:    len = 5'd11;
            4'd5:    len = 5'd17;
            4'd6:    len = 5'd19;
            4'd7:    len = 5'd20;
            4'd8:    len = 5'd8;
            4'd9:    len = 5'd8;
            4'd10:   len = 5'd7;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

    // Names are kept in lower case, right-justified: the last character sits lowest.
    function automatic logic [159:0] name_row(input logic [NAME_IDX_W-1:0] k);
        logic [159:0] row;
        unique case (k)
            4'd0:    row = 160'("host:");
            4'd1:    row = 160'("connection:");
            4'd2:    row = 160'("transfer-encoding:");
            4'd3:    row = 160'("te:");
            4'd4:    row = 160'("keep-alive:");
            4'd5:    row = 160'("proxy-connection:");
            4'd6:    row = 160'("proxy-authenticate:");
            4'd7:    row = 160'("proxy-authorization:");
            4'd8:    row = 160'("upgrade:");
            4'd9:    row = 160'("trailer:");
            4'd10:   row = 160'("expect:");
            default: row = '0;
        endcase
        return row;
    endfunction

    function automatic logic [7:0] name_char(input logic [NAME_IDX_W-1:0] k,
                                             input logic [NAME_POS_W-1:0] pos);
        logic [159:0]          row;
        logic [NAME_POS_W-1:0] len;
        row = name_row(k);
        len = name_len(k);
        if (pos < len) begin
            return row[(int'(len) - 1 - int'(pos)) * 8 +: 8];
        end
        return 8'h00;
    endfunction

    function automatic logic [7:0] tail_head_char(input logic [3:0] i);
        return TAIL_HEAD[(TAIL_HEAD_LEN - 1 - int'(i)) * 8 +: 8];
    endfunction

    function automatic logic [7:0] tail_rest_char(input logic [4:0] i);
        if (int'(i) < TAIL_REST_LEN) begin
            return TAIL_REST[(TAIL_REST_LEN - 1 - int'(i)) * 8 +: 8];
        end
        return 8'h00;
    endfunction

endpackage

[hdl/hhf_port_bcd.sv]
// Serial binary to decimal converter for the upstream port number.
// Uses hhf_pkg; restarts on reset and on every write of the port register.
module hhf_port_bcd (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       load,
    input  logic [15:0]                value,
    output logic                       ready,
    output logic [hhf_pkg::BCD_W-1:0]  bcd
);

    logic                      busy_reg, busy_next;
    logic [3:0]                step_reg, step_next;
    logic [15:0]               bin_reg, bin_next;
    logic [hhf_pkg::BCD_W-1:0] bcd_reg, bcd_next;
    logic [hhf_pkg::BCD_W-1:0] adj;

    always_comb begin
        for (int d = 0; d < hhf_pkg::BCD_W / 4; d++) begin
            adj[4*d +: 4] = (bcd_reg[4*d +: 4] >= 4'd5) ? bcd_reg[4*d +: 4] + 4'd3
                                                         : bcd_reg[4*d +: 4];
        end
    end

    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        if (load) begin
            busy_next = 1'b1;
            step_next = '0;
            bin_next  = value;
            bcd_next  = '0;
        end else if (busy_reg) begin
            bcd_next  = {adj[hhf_pkg::BCD_W-2:0], bin_reg[15]};
            bin_next  = {bin_reg[14:0], 1'b0};
            step_next = step_reg + 4'd1;
            if (step_reg == 4'(hhf_pkg::CONV_STEPS - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b1;
            step_reg <= '0;
            bin_reg  <= hhf_pkg::PORT_RESET;
            bcd_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            bin_reg  <= bin_next;
            bcd_reg  <= bcd_next;
        end
    end

    assign ready = !busy_reg;
    assign bcd   = bcd_reg;

endmodule

[hdl/hhf_line_filter.sv]
// Per-byte line state and verdict logic of the header filter.
// Uses hhf_pkg; the caller registers the incoming item and the produced result.
module hhf_line_filter (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               item_fire,
    input  logic [7:0]         data_byte,
    input  logic               item_last,
    input  logic [15:0]        buffer_size,
    output logic               res_valid,
    output hhf_pkg::result_t   res,
    output hhf_pkg::tail_req_t tail_req
);

    logic                                in_req_reg, in_req_next;
    logic [hhf_pkg::LEN_W-1:0]           lc_reg, lc_next;
    logic [hhf_pkg::NUM_NAMES-1:0]       alive_reg, alive_next;
    logic                                matched_reg, matched_next;
    logic [1:0]                          cr_hist_reg, cr_hist_next;
    logic                                cr_emb_reg, cr_emb_next;
    logic                                first_cr_reg, first_cr_next;
    logic [hhf_pkg::LEN_W-1:0]           oc_reg, oc_next;
    logic                                stopped_reg, stopped_next;

    logic                                ends;
    logic                                is_cr;
    logic [7:0]                          byte_lc;
    logic [hhf_pkg::LEN_W-1:0]           lc_inc;
    logic [hhf_pkg::NUM_NAMES-1:0]       alive_tb;
    logic                                matched_tb;
    logic                                first_cr_tb;
    logic                                cr_emb_tb;
    logic [hhf_pkg::LEN_W:0]             oc_sum;
    logic [hhf_pkg::LEN_W-1:0]           oc_fwd;
    logic                                room;
    hhf_pkg::verdict_t                   line_verdict;

    assign is_cr   = (data_byte == hhf_pkg::CHAR_CR);
    assign ends    = (data_byte == hhf_pkg::CHAR_LF) || item_last;
    assign byte_lc = hhf_pkg::to_lower(data_byte);
    assign lc_inc  = (lc_reg == hhf_pkg::LEN_MAX) ? lc_reg : lc_reg + 1'b1;

    always_comb begin
        logic [hhf_pkg::NAME_POS_W-1:0] len;
        logic                           active;
        logic                           hit;
        alive_tb   = alive_reg;
        matched_tb = matched_reg;
        for (int k = 0; k < hhf_pkg::NUM_NAMES; k++) begin
            len    = hhf_pkg::name_len(hhf_pkg::NAME_IDX_W'(k));
            active = alive_reg[k] && (lc_reg < hhf_pkg::LEN_W'(len));
            hit    = byte_lc == hhf_pkg::name_char(hhf_pkg::NAME_IDX_W'(k),
                                                   lc_reg[hhf_pkg::NAME_POS_W-1:0]);
            if (active && !hit) begin
                alive_tb[k] = 1'b0;
            end
            if (active && hit && (lc_reg == hhf_pkg::LEN_W'(len - 1'b1))) begin
                matched_tb = 1'b1;
            end
        end
    end

    assign first_cr_tb = (lc_reg == '0) ? is_cr : first_cr_reg;
    assign cr_emb_tb   = cr_emb_reg | cr_hist_reg[1];

    assign oc_sum = {1'b0, oc_reg} + {1'b0, lc_inc};
    assign oc_fwd = oc_sum[hhf_pkg::LEN_W] ? hhf_pkg::LEN_MAX : oc_sum[hhf_pkg::LEN_W-1:0];
    assign room   = ({2'b00, oc_reg} + {2'b00, lc_inc} + {2'b00, hhf_pkg::HEADROOM})
                    <= {2'b00, buffer_size};

    always_comb begin
        priority if (lc_inc == 16'd1 || (lc_inc == 16'd2 && first_cr_tb)) begin
            line_verdict = hhf_pkg::VERDICT_BLANK;
        end else if (matched_tb) begin
            line_verdict = hhf_pkg::VERDICT_HOP;
        end else if (cr_emb_tb) begin
            line_verdict = hhf_pkg::VERDICT_SMUGGLE;
        end else if (room) begin
            line_verdict = hhf_pkg::VERDICT_FORWARD;
        end else begin
            line_verdict = hhf_pkg::VERDICT_NO_ROOM;
        end
    end

    always_comb begin
        in_req_next   = in_req_reg;
        lc_next       = lc_reg;
        alive_next    = alive_reg;
        matched_next  = matched_reg;
        cr_hist_next  = cr_hist_reg;
        cr_emb_next   = cr_emb_reg;
        first_cr_next = first_cr_reg;
        oc_next       = oc_reg;
        stopped_next  = stopped_reg;
        res_valid     = 1'b0;
        res = '{kind: hhf_pkg::KIND_VERDICT, verdict: hhf_pkg::VERDICT_FORWARD,
                line_length: '0, tail_byte: '0, total_length: oc_reg, last: 1'b0};
        tail_req = '{start: 1'b0, out_count: oc_reg};
        if (item_fire) begin
            if (in_req_reg) begin
                lc_next = lc_inc;
                if (ends) begin
                    res_valid       = 1'b1;
                    res.verdict     = hhf_pkg::VERDICT_REQUEST;
                    res.line_length = lc_inc;
                    in_req_next     = 1'b0;
                    lc_next         = '0;
                end
            end else if (!stopped_reg) begin
                lc_next       = lc_inc;
                alive_next    = alive_tb;
                matched_next  = matched_tb;
                cr_hist_next  = {cr_hist_reg[0], is_cr};
                cr_emb_next   = cr_emb_tb;
                first_cr_next = first_cr_tb;
                if (ends) begin
                    if (line_verdict == hhf_pkg::VERDICT_FORWARD) begin
                        oc_next = oc_fwd;
                    end
                    if (line_verdict == hhf_pkg::VERDICT_BLANK ||
                        line_verdict == hhf_pkg::VERDICT_SMUGGLE) begin
                        stopped_next = 1'b1;
                    end
                    res_valid        = 1'b1;
                    res.verdict      = line_verdict;
                    res.line_length  = lc_inc;
                    res.total_length = oc_next;
                    lc_next          = '0;
                    alive_next       = '1;
                    matched_next     = 1'b0;
                    cr_hist_next     = '0;
                    cr_emb_next      = 1'b0;
                    first_cr_next    = 1'b0;
                end
            end
            if (item_last) begin
                tail_req.start     = 1'b1;
                tail_req.out_count = oc_next;
                in_req_next        = 1'b1;
                lc_next            = '0;
                alive_next         = '1;
                matched_next       = 1'b0;
                cr_hist_next       = '0;
                cr_emb_next        = 1'b0;
                first_cr_next      = 1'b0;
                oc_next            = '0;
                stopped_next       = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_req_reg   <= 1'b1;
            lc_reg       <= '0;
            alive_reg    <= '1;
            matched_reg  <= 1'b0;
            cr_hist_reg  <= '0;
            cr_emb_reg   <= 1'b0;
            first_cr_reg <= 1'b0;
            oc_reg       <= '0;
            stopped_reg  <= 1'b0;
        end else begin
            in_req_reg   <= in_req_next;
            lc_reg       <= lc_next;
            alive_reg    <= alive_next;
            matched_reg  <= matched_next;
            cr_hist_reg  <= cr_hist_next;
            cr_emb_reg   <= cr_emb_next;
            first_cr_reg <= first_cr_next;
            oc_reg       <= oc_next;
            stopped_reg  <= stopped_next;
        end
    end

endmodule

[hdl/hhf_tail_gen.sv]
// Sequencer that emits the appended Host/Connection tail one byte per result.
// Uses hhf_pkg; takes the port digits from hhf_port_bcd.
module hhf_tail_gen (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  hhf_pkg::tail_req_t         tail_req,
    input  logic                       out_free,
    input  logic                       digits_ready,
    input  logic [hhf_pkg::BCD_W-1:0]  bcd,
    input  logic [15:0]                buffer_size,
    output logic                       busy,
    output logic                       emit,
    output hhf_pkg::result_t           res
);

    logic                               busy_reg, busy_next;
    logic [hhf_pkg::TAIL_IDX_W-1:0]     idx_reg, idx_next;
    logic [hhf_pkg::LEN_W-1:0]          oc_reg, oc_next;

    logic [2:0]                         nd;
    logic [hhf_pkg::TAIL_IDX_W-1:0]     tail_len;
    logic [hhf_pkg::TAIL_IDX_W-1:0]     j;
    logic [2:0]                         sel;
    logic [3:0]                         digit;
    logic [4:0]                         rest_idx;
    logic [7:0]                         char_out;
    logic                               fits;
    logic                               is_last;
    logic [hhf_pkg::LEN_W-1:0]          oc_inc;

    always_comb begin
        priority if (bcd[19:16] != 4'd0) begin
            nd = 3'd5;
        end else if (bcd[15:12] != 4'd0) begin
            nd = 3'd4;
        end else if (bcd[11:8] != 4'd0) begin
            nd = 3'd3;
        end else if (bcd[7:4] != 4'd0) begin
            nd = 3'd2;
        end else begin
            nd = 3'd1;
        end
    end

    assign tail_len = hhf_pkg::TAIL_IDX_W'(hhf_pkg::TAIL_BASE_LEN) + {3'b000, nd};
    assign j        = idx_reg - hhf_pkg::TAIL_IDX_W'(hhf_pkg::TAIL_HEAD_LEN);
    assign sel      = nd - 3'd1 - j[2:0];
    assign rest_idx = 5'(j - {3'b000, nd});

    always_comb begin
        unique case (sel)
            3'd0:    digit = bcd[3:0];
            3'd1:    digit = bcd[7:4];
            3'd2:    digit = bcd[11:8];
            3'd3:    digit = bcd[15:12];
            3'd4:    digit = bcd[19:16];
            default: digit = 4'd0;
        endcase
    end

    always_comb begin
        priority if (idx_reg < hhf_pkg::TAIL_IDX_W'(hhf_pkg::TAIL_HEAD_LEN)) begin
            char_out = hhf_pkg::tail_head_char(idx_reg[3:0]);
        end else if (j < {3'b000, nd}) begin
            char_out = hhf_pkg::CHAR_ZERO + {4'b0000, digit};
        end else begin
            char_out = hhf_pkg::tail_rest_char(rest_idx);
        end
    end

    assign emit    = busy_reg && out_free && digits_ready;
    assign fits    = oc_reg < buffer_size;
    assign oc_inc  = oc_reg + 1'b1;
    assign is_last = !fits || (idx_reg + 1'b1 == tail_len) || (oc_inc == buffer_size);

    always_comb begin
        res = '{kind: hhf_pkg::KIND_TAIL, verdict: hhf_pkg::VERDICT_FORWARD,
                line_length: '0, tail_byte: fits ? char_out : 8'h00,
                total_length: fits ? oc_inc : oc_reg, last: is_last};
    end

    always_comb begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        oc_next   = oc_reg;
        if (tail_req.start) begin
            busy_next = 1'b1;
            idx_next  = '0;
            oc_next   = tail_req.out_count;
        end else if (emit) begin
            idx_next = idx_reg + 1'b1;
            oc_next  = res.total_length;
            if (is_last) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        oc_reg <= oc_next;
    end

    assign busy = busy_reg;

endmodule

[hdl/http_hop_header_filter.sv]
// Top level of the hop-by-hop header filter: input and result registers,
// configuration registers, and the line filter, tail sequencer and port converter.
// Each header byte is one item, taken one per cycle through the input and result registers
// unless the tail or the output stalls. A byte that ends a line yields one verdict item;
// the last byte of a block is followed by the appended tail of 40 to 44 items, fewer if
// the buffer runs out, one per cycle while the output and port digits are ready. The
// digits come from a bit-serial converter that restarts on reset or a port write. Input
// ready also follows m_axis_tready in the same cycle when the input register is full.
module http_hop_header_filter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_index,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [2:0] verdict, [18:3] line_length,
                                        // [26:19] tail_byte, [42:27] total_length
    output logic        m_axis_tuser,   // [0] result_kind
    output logic        m_axis_tlast
);

    logic [15:0]                 port_number_reg, port_number_next;
    logic [15:0]                 buffer_size_reg, buffer_size_next;
    logic                        in_valid_reg, in_valid_next;
    logic [7:0]                  in_data_reg, in_data_next;
    logic                        in_last_reg, in_last_next;
    logic                        m_valid_reg, m_valid_next;
    hhf_pkg::result_t            m_res_reg, m_res_next;

    logic                        out_free;
    logic                        item_fire;
    logic                        s_accept;
    logic                        port_load;
    logic                        res_valid;
    hhf_pkg::result_t            line_res;
    hhf_pkg::tail_req_t          tail_req;
    logic                        tail_busy;
    logic                        tail_emit;
    hhf_pkg::result_t            tail_res;
    logic                        digits_ready;
    logic [hhf_pkg::BCD_W-1:0]   bcd;

    assign out_free      = !m_valid_reg || m_axis_tready;
    assign item_fire     = in_valid_reg && !tail_busy && out_free;
    assign s_axis_tready = !in_valid_reg || item_fire;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        port_number_next = port_number_reg;
        buffer_size_next = buffer_size_reg;
        port_load        = 1'b0;
        if (cfg_wr_en) begin
            unique case (hhf_pkg::cfg_reg_t'(cfg_wr_index))
                hhf_pkg::CFG_PORT_NUMBER: begin
                    port_number_next = cfg_wr_data;
                    port_load        = 1'b1;
                end
                hhf_pkg::CFG_BUFFER_SIZE: begin
                    buffer_size_next = cfg_wr_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        in_data_next  = in_data_reg;
        in_last_next  = in_last_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
            in_data_next  = s_axis_tdata;
            in_last_next  = s_axis_tlast;
        end else if (item_fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (tail_emit) begin
            m_valid_next = 1'b1;
            m_res_next   = tail_res;
        end else if (item_fire && res_valid) begin
            m_valid_next = 1'b1;
            m_res_next   = line_res;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            port_number_reg <= hhf_pkg::PORT_RESET;
            buffer_size_reg <= hhf_pkg::BUF_RESET;
            in_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            port_number_reg <= port_number_next;
            buffer_size_reg <= buffer_size_next;
            in_valid_reg    <= in_valid_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_data_reg <= in_data_next;
        in_last_reg <= in_last_next;
        m_res_reg   <= m_res_next;
    end

    hhf_line_filter u_line_filter (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_fire   (item_fire),
        .data_byte   (in_data_reg),
        .item_last   (in_last_reg),
        .buffer_size (buffer_size_reg),
        .res_valid   (res_valid),
        .res         (line_res),
        .tail_req    (tail_req)
    );

    hhf_port_bcd u_port_bcd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (port_load),
        .value   (port_number_next),
        .ready   (digits_ready),
        .bcd     (bcd)
    );

    hhf_tail_gen u_tail_gen (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .tail_req     (tail_req),
        .out_free     (out_free),
        .digits_ready (digits_ready),
        .bcd          (bcd),
        .buffer_size  (buffer_size_reg),
        .busy         (tail_busy),
        .emit         (tail_emit),
        .res          (tail_res)
    );

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {5'b00000, m_res_reg.total_length, m_res_reg.tail_byte,
                            m_res_reg.line_length, m_res_reg.verdict};
    assign m_axis_tuser  = m_res_reg.kind;
    assign m_axis_tlast  = m_res_reg.last;

`ifndef SYNTHESIS
    a_no_item_during_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        item_fire |-> !tail_busy)
        else $error("A header item was processed while the tail was being emitted.");

    a_tail_follows_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (tail_busy && !$past(tail_busy)) |-> $past(item_fire && in_last_reg))
        else $error("The tail started without a final item of a block.");

    a_tail_done_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |-> !tail_busy)
        else $error("The tail sequencer is still running after its final item.");
`endif

endmodule

[bench/tb_http_hop_header_filter.sv]
// Self-checking testbench for the hop-by-hop header filter: it sends whole header
// blocks and predicts every line verdict and tail item from its own model of the filter.
// Depends on hhf_pkg and http_hop_header_filter only.
`timescale 1ns / 1ps

module tb_http_hop_header_filter;

    localparam int SETTLE_CYCLES  = 64;
    localparam int WATCHDOG_LIMIT = 2000;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic        cfg_wr_index  = 1'b0;
    logic [15:0] cfg_wr_data   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    http_hop_header_filter i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_index  (cfg_wr_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    string hop_names [0:hhf_pkg::NUM_NAMES-1] = '{
        "host:", "connection:", "transfer-encoding:", "te:", "keep-alive:",
        "proxy-connection:", "proxy-authenticate:", "proxy-authorization:",
        "upgrade:", "trailer:", "expect:"
    };

    // Mirror of the filter state and its registers.
    logic [15:0]                   port_cfg   = hhf_pkg::PORT_RESET;
    logic [15:0]                   budget_cfg = hhf_pkg::BUF_RESET;
    logic                          req_line   = 1'b1;
    logic [hhf_pkg::LEN_W-1:0]     line_len   = '0;
    logic [hhf_pkg::NUM_NAMES-1:0] names_live = '1;
    logic                          name_hit   = 1'b0;
    logic [1:0]                    cr_last2   = '0;
    logic                          cr_inside  = 1'b0;
    logic                          starts_cr  = 1'b0;
    logic [hhf_pkg::LEN_W-1:0]     out_total  = '0;
    logic                          halted     = 1'b0;

    hhf_pkg::result_t expected_results [$];
    logic [7:0]       block_bytes [$];
    hhf_pkg::result_t want;
    int               errors       = 0;
    int               items_sent   = 0;
    int               quiet_cycles = 0;
    int               stall_left   = 0;
    int               stall_draw;
    bit               tx_burst     = 1'b0;
    bit               rx_burst     = 1'b0;

    function automatic void clear_line_state();
        line_len   = '0;
        names_live = '1;
        name_hit   = 1'b0;
        cr_last2   = '0;
        cr_inside  = 1'b0;
        starts_cr  = 1'b0;
    endfunction

    function automatic void push_verdict(input hhf_pkg::verdict_t v);
        expected_results.push_back('{kind: hhf_pkg::KIND_VERDICT, verdict: v,
                                     line_length: line_len, tail_byte: 8'h00,
                                     total_length: out_total, last: 1'b0});
    endfunction

    function automatic void predict_tail();
        string tail;
        int    avail;
        int    count;
        tail = {$sformatf("Host: %0d.%0d.%0d.%0d:%0d", 127, 0, 0, 1, port_cfg),
                "\015\nConnection: close\015\n\015\n"};
        avail = (budget_cfg > out_total) ? int'(budget_cfg) - int'(out_total) : 0;
        count = (tail.len() < avail) ? tail.len() : avail;
        if (count == 0) begin
            expected_results.push_back('{kind: hhf_pkg::KIND_TAIL,
                                         verdict: hhf_pkg::VERDICT_FORWARD,
                                         line_length: '0, tail_byte: 8'h00,
                                         total_length: out_total, last: 1'b1});
        end else begin
            for (int i = 0; i < count; i++) begin
                out_total = out_total + 1'b1;
                expected_results.push_back('{kind: hhf_pkg::KIND_TAIL,
                                             verdict: hhf_pkg::VERDICT_FORWARD,
                                             line_length: '0, tail_byte: tail[i],
                                             total_length: out_total,
                                             last: (i == count - 1)});
            end
        end
        req_line  = 1'b1;
        out_total = '0;
        halted    = 1'b0;
        clear_line_state();
    endfunction

    function automatic void predict_filter(input logic [7:0] data, input logic final_byte);
        logic               ends;
        logic [7:0]         lc;
        hhf_pkg::verdict_t  v;
        ends = (data == hhf_pkg::CHAR_LF) || final_byte;
        lc   = (data >= "A" && data <= "Z") ? data + 8'd32 : data;
        if (req_line) begin
            if (line_len != hhf_pkg::LEN_MAX) line_len = line_len + 1'b1;
            if (ends) begin
                push_verdict(hhf_pkg::VERDICT_REQUEST);
                req_line = 1'b0;
                clear_line_state();
            end
        end else if (!halted) begin
            if (line_len == 0) starts_cr = (data == hhf_pkg::CHAR_CR);
            if (cr_last2[1]) cr_inside = 1'b1;
            cr_last2 = {cr_last2[0], data == hhf_pkg::CHAR_CR};
            for (int k = 0; k < hhf_pkg::NUM_NAMES; k++) begin
                if (names_live[k] && line_len < hop_names[k].len()) begin
                    if (lc != hop_names[k][line_len]) begin
                        names_live[k] = 1'b0;
                    end else if (line_len == hop_names[k].len() - 1) begin
                        name_hit = 1'b1;
                    end
                end
            end
            if (line_len != hhf_pkg::LEN_MAX) line_len = line_len + 1'b1;
            if (ends) begin
                if (line_len == 1 || (line_len == 2 && starts_cr)) begin
                    v      = hhf_pkg::VERDICT_BLANK;
                    halted = 1'b1;
                end else if (name_hit) begin
                    v = hhf_pkg::VERDICT_HOP;
                end else if (cr_inside) begin
                    v      = hhf_pkg::VERDICT_SMUGGLE;
                    halted = 1'b1;
                end else if (int'(out_total) + int'(line_len) + int'(hhf_pkg::HEADROOM)
                             <= int'(budget_cfg)) begin
                    v         = hhf_pkg::VERDICT_FORWARD;
                    out_total = out_total + line_len;
                end else begin
                    v = hhf_pkg::VERDICT_NO_ROOM;
                end
                push_verdict(v);
                clear_line_state();
            end
        end
        if (final_byte) predict_tail();
    endfunction

    // Block building.
    function automatic void add_byte(input logic [7:0] value);
        block_bytes.push_back(value);
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endfunction

    function automatic void add_mixed_case(input string s);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++) begin
            c = s[i];
            if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) c = c - 8'd32;
            add_byte(c);
        end
    endfunction

    function automatic void add_word(input int lo, input int hi);
        repeat ($urandom_range(lo, hi)) add_byte(8'($urandom_range(8'h21, 8'h7e)));
    endfunction

    function automatic void add_noise_byte();
        case ($urandom_range(0, 7))
            0: add_byte(hhf_pkg::CHAR_CR);
            1: add_byte(hhf_pkg::CHAR_LF);
            default: add_byte(8'($urandom_range(0, 255)));
        endcase
    endfunction

    function automatic void add_line_end();
        add_text(($urandom_range(0, 4) == 0) ? "\n" : "\015\n");
    endfunction

    function automatic void add_header_line();
        int    sel;
        string name;
        sel  = $urandom_range(0, 9);
        name = hop_names[$urandom_range(0, hhf_pkg::NUM_NAMES - 1)];
        if (sel <= 3) begin
            add_mixed_case(name);
            add_text(" ");
            add_word(0, 8);
        end else if (sel <= 5) begin
            add_mixed_case("x-");
            add_word(1, 6);
            add_text(": ");
            add_word(0, 8);
        end else if (sel == 6) begin
            add_mixed_case(name.substr(0, $urandom_range(0, name.len() - 2)));
        end else if (sel == 7) begin
            add_word(1, 4);
            add_byte(hhf_pkg::CHAR_CR);
            add_word(1, 4);
        end else if (sel == 8) begin
            repeat ($urandom_range(1, 6)) add_noise_byte();
        end else begin
            add_mixed_case(name);
            add_byte(hhf_pkg::CHAR_CR);
            add_word(1, 4);
        end
        add_line_end();
    endfunction

    function automatic void build_random_block();
        int ending;
        block_bytes.delete();
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 24)) add_noise_byte();
            return;
        end
        add_text("GET /");
        add_word(1, 10);
        add_text("\015\n");
        repeat ($urandom_range(0, 5)) add_header_line();
        ending = $urandom_range(0, 9);
        if (ending < 6) begin
            add_text("\015\n");
            repeat ($urandom_range(0, 2)) add_noise_byte();
        end else if (ending < 8) begin
            add_byte(hhf_pkg::CHAR_LF);
        end else begin
            add_header_line();
            void'(block_bytes.pop_back());
            if ($urandom_range(0, 1) == 1) void'(block_bytes.pop_back());
        end
    endfunction

    // Driving.
    task automatic send_byte(input logic [7:0] value, input logic final_byte);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tlast  <= final_byte;
        do @(posedge aclk); while (!s_axis_tready);
        predict_filter(value, final_byte);
        items_sent++;
    endtask

    task automatic send_block();
        for (int i = 0; i < block_bytes.size(); i++) begin
            send_byte(block_bytes[i], i == block_bytes.size() - 1);
        end
        block_bytes.delete();
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_results.size() != 0);
    endtask

    task automatic write_register(input hhf_pkg::cfg_reg_t index, input logic [15:0] value);
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= index;
        cfg_wr_data  <= value;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
        if (index == hhf_pkg::CFG_PORT_NUMBER) begin
            port_cfg = value;
        end else begin
            budget_cfg = value;
        end
    endtask

    // Tests.
    task automatic test_directed_lines();
        add_byte(8'h00);
        add_text("\n");
        add_text("tE:\015");
        add_text("1\n");
        add_byte(8'hff);
        add_text("A\n");
        add_text("\n");
        add_text("Q");
        send_block();

        write_register(hhf_pkg::CFG_BUFFER_SIZE, 16'd64);
        add_text("R\nab\na\015");
        add_text("b\n");
        send_block();
        add_text("R\nHos");
        send_block();
        add_text("R\n\015");
        send_block();
    endtask

    task automatic test_random_traffic(input logic [15:0] port, input logic [15:0] budget,
                                       input int item_goal);
        int first_item;
        write_register(hhf_pkg::CFG_PORT_NUMBER, port);
        write_register(hhf_pkg::CFG_BUFFER_SIZE, budget);
        first_item = items_sent;
        while (items_sent - first_item < item_goal) begin
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            build_random_block();
            send_block();
            if ($urandom_range(0, 5) == 0) wait_for_results();
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_lines();
        test_random_traffic(16'd0, 16'hffff, 50);
        test_random_traffic(16'hffff, 16'd64, 50);
        test_random_traffic(16'($urandom_range(0, 65535)), 16'($urandom_range(64, 400)), 50);
        test_random_traffic(16'($urandom_range(1, 99)), 16'($urandom_range(64, 65535)), 50);
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("http_hop_header_filter: match");
        end else begin
            $display("http_hop_header_filter: mismatch");
        end
        $finish;
    end

    // Result side: random stalls and checking.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            stall_draw = rx_burst ? 0 : $urandom_range(0, 14);
            m_axis_tready <= (stall_draw == 0);
            stall_left    <= stall_draw;
        end else if (stall_left > 1) begin
            stall_left <= stall_left - 1;
        end else begin
            stall_left    <= 0;
            m_axis_tready <= 1'b1;
        end
    end

    task automatic check_field(input string field, input logic [15:0] want_v,
                               input logic [15:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s expected %0h, got %0h", $time, field, want_v, got_v);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected item, expected none, got tdata %h tuser %b tlast %b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                errors++;
            end else begin
                want = expected_results.pop_front();
                check_field("result_kind", 16'(want.kind), 16'(m_axis_tuser));
                check_field("verdict", 16'(want.verdict), 16'(m_axis_tdata[2:0]));
                check_field("line_length", want.line_length, m_axis_tdata[18:3]);
                check_field("tail_byte", 16'(want.tail_byte), 16'(m_axis_tdata[26:19]));
                check_field("total_length", want.total_length, m_axis_tdata[42:27]);
                check_field("last", 16'(want.last), 16'(m_axis_tlast));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
            $display("http_hop_header_filter: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
